>>> design/nvrr_pkg.sv
// Shared types and constants for the NV21/NV12 resize-rotate-to-BGR core.
// Holds the transaction structs, op and register codes, and the controller command struct.
package nvrr_pkg;

    // Fixed field widths of the transactions
    localparam int ADDR_W      = 20;
    localparam int COORD_W     = 9;
    localparam int CFG_DIM_W   = 11;
    localparam int CFG_INDEX_W = 4;

    // Operation codes
    localparam logic [1:0] OP_LOAD_LUMA   = 2'd0;
    localparam logic [1:0] OP_LOAD_CHROMA = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_ORDER  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION_CODE = 4'd3;

    // Configuration reset values
    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic                 CHROMA_ORDER_RST = 1'b1;
    localparam logic [1:0]           ROTATION_RST     = 2'd0;

    // Rotation codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_90   = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_270  = 2'd3;

    // BT.601 full range, Q2.14
    localparam int               Q_FRAC = 14;
    localparam logic signed [15:0] K_RV = 16'sd22987;
    localparam logic signed [15:0] K_GU = -16'sd5636;
    localparam logic signed [15:0] K_GV = -16'sd11698;
    localparam logic signed [15:0] K_BU = 16'sd29049;

    typedef struct packed {
        logic [1:0]         op;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] blue;
        logic signed [7:0] green;
        logic signed [7:0] red;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       wr_luma;
        logic       wr_chroma;
        logic       capture;
        logic       scale;
        logic       quot;
        logic       addr;
        logic       rd;
        logic [1:0] pair;
        logic       acc_clear;
        logic       acc;
        logic       conv;
        logic       out_load;
    } nvrr_cmd_t;

endpackage

>>> design/nvrr_ctrl.sv
// Controller FSM for the NV21/NV12 resize-rotate-to-BGR core.
// Sequences load and compute transactions; depends on nvrr_pkg.
module nvrr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    input  logic                out_stall,
    output logic                in_stall,
    output logic                out_valid,
    output nvrr_pkg::nvrr_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SCALE = 11'b000_0000_0010,
        S_QUOT  = 11'b000_0000_0100,
        S_ADDR  = 11'b000_0000_1000,
        S_RD0   = 11'b000_0001_0000,
        S_RD1   = 11'b000_0010_0000,
        S_RD2   = 11'b000_0100_0000,
        S_RD3   = 11'b000_1000_0000,
        S_ACC   = 11'b001_0000_0000,
        S_CONV  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd.wr_luma   = (in_op == nvrr_pkg::OP_LOAD_LUMA);
                    cmd.wr_chroma = (in_op == nvrr_pkg::OP_LOAD_CHROMA);
                    if (in_op == nvrr_pkg::OP_COMPUTE)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.rd     = 1'b1;
                cmd.pair   = 2'd0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd        = 1'b1;
                cmd.pair      = 2'd1;
                cmd.acc_clear = 1'b1;
                state_next    = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd     = 1'b1;
                cmd.pair   = 2'd2;
                cmd.acc    = 1'b1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd     = 1'b1;
                cmd.pair   = 2'd3;
                cmd.acc    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/nvrr_datapath.sv
// Datapath for the NV21/NV12 resize-rotate-to-BGR core: config registers, frame
// stores, index scaling, chroma averaging and color conversion. Depends on nvrr_pkg.
module nvrr_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int OUT_SIZE   = 384
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nvrr_pkg::nvrr_cmd_t                  cmd,
    input  nvrr_pkg::in_item_t                   in_item,
    input  logic                                 cfg_we,
    input  logic [nvrr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nvrr_pkg::CFG_DIM_W-1:0]       cfg_data,
    output nvrr_pkg::out_item_t                  out_item
);

    // Store geometry
    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = LUMA_DEPTH / 2;
    localparam int BANK_DEPTH   = (CHROMA_DEPTH + 1) / 2;
    localparam int LAW          = $clog2(LUMA_DEPTH);
    localparam int CAW          = $clog2(CHROMA_DEPTH);
    localparam int BAW          = (CAW > 1) ? CAW - 1 : 1;
    localparam int AXW          = ((LAW > nvrr_pkg::ADDR_W) ? LAW : nvrr_pkg::ADDR_W) + 1;
    localparam int CXW          = ((CAW > nvrr_pkg::ADDR_W) ? CAW : nvrr_pkg::ADDR_W) + 1;

    // Dimension and index widths
    localparam int DWW = $clog2(MAX_WIDTH + 1);
    localparam int DHW = $clog2(MAX_HEIGHT + 1);
    localparam int NW  = (DWW > DHW) ? DWW : DHW;
    localparam int FW  = (NW > nvrr_pkg::CFG_DIM_W) ? NW : nvrr_pkg::CFG_DIM_W;
    localparam int PW  = $clog2(OUT_SIZE);
    localparam int XW  = (PW > nvrr_pkg::COORD_W) ? PW : nvrr_pkg::COORD_W;
    localparam logic [PW-1:0] LAST = PW'(OUT_SIZE - 1);

    // Exact division by OUT_SIZE through a reciprocal: prod < 2^MW, error term < 2^PW
    localparam int MW = PW + NW;
    localparam int K  = MW + PW;
    localparam int RW = MW + 1;
    localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE);
    localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
    localparam int QPW = MW + RW;

    localparam int PRODW = 26;

    // Configuration registers
    logic [nvrr_pkg::CFG_DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic                           chroma_order_reg;
    logic [1:0]                     rotation_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= nvrr_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= nvrr_pkg::FRAME_HEIGHT_RST;
            chroma_order_reg  <= nvrr_pkg::CHROMA_ORDER_RST;
            rotation_code_reg <= nvrr_pkg::ROTATION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nvrr_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                nvrr_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                nvrr_pkg::CFG_CHROMA_ORDER:  chroma_order_reg  <= cfg_data[0];
                nvrr_pkg::CFG_ROTATION_CODE: rotation_code_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Load address wrap into the stores
    logic [AXW-1:0] waddr_lx;
    logic [CXW-1:0] waddr_cx;
    logic [LAW-1:0] lw_low, lw_idx;
    logic [CAW-1:0] cw_low, cw_idx;
    logic [CAW:0]   cw_ext;
    logic [BAW-1:0] cw_bidx;

    always_comb
    begin
        waddr_lx = AXW'(in_item.addr);
        waddr_cx = CXW'(in_item.addr);
        lw_low   = waddr_lx[LAW-1:0];
        cw_low   = waddr_cx[CAW-1:0];
        lw_idx   = ({1'b0, lw_low} >= (LAW+1)'(LUMA_DEPTH)) ?
                   lw_low - LAW'(LUMA_DEPTH) : lw_low;
        cw_idx   = ({1'b0, cw_low} >= (CAW+1)'(CHROMA_DEPTH)) ?
                   cw_low - CAW'(CHROMA_DEPTH) : cw_low;
        cw_ext   = {1'b0, cw_idx};
        cw_bidx  = BAW'(cw_ext >> 1);
    end

    // Capture: saturate coordinates, undo rotation, saturate frame size
    logic [XW-1:0] x_ext, y_ext;
    logic [PW-1:0] x_sat, y_sat, px_next, py_next;
    logic [FW-1:0] fw_ext, fh_ext;
    logic [NW-1:0] w_next, h_next;
    logic [PW-1:0] px_reg, py_reg;
    logic [NW-1:0] w_reg, h_reg;

    always_comb
    begin
        x_ext  = XW'(in_item.out_x);
        y_ext  = XW'(in_item.out_y);
        x_sat  = (x_ext > XW'(LAST)) ? LAST : x_ext[PW-1:0];
        y_sat  = (y_ext > XW'(LAST)) ? LAST : y_ext[PW-1:0];
        case (rotation_code_reg)
            nvrr_pkg::ROT_90:
            begin
                px_next = LAST - y_sat;
                py_next = x_sat;
            end
            nvrr_pkg::ROT_180:
            begin
                px_next = LAST - x_sat;
                py_next = LAST - y_sat;
            end
            nvrr_pkg::ROT_270:
            begin
                px_next = y_sat;
                py_next = LAST - x_sat;
            end
            default:
            begin
                px_next = x_sat;
                py_next = y_sat;
            end
        endcase
        fw_ext = FW'(frame_width_reg);
        fh_ext = FW'(frame_height_reg);
        w_next = (fw_ext < FW'(2)) ? NW'(2) :
                 (fw_ext > FW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : fw_ext[NW-1:0];
        h_next = (fh_ext < FW'(2)) ? NW'(2) :
                 (fh_ext > FW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : fh_ext[NW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            w_reg  <= w_next;
            h_reg  <= h_next;
        end
    end

    // Scale step: products of even/odd grid positions and frame size
    logic [PW-1:0] xe, ye;
    logic [MW-1:0] colp0_reg, colp1_reg, rowp0_reg, rowp1_reg;

    assign xe = px_reg & ~PW'(1);
    assign ye = py_reg & ~PW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            colp0_reg <= MW'(xe) * MW'(w_reg);
            colp1_reg <= MW'(xe | PW'(1)) * MW'(w_reg);
            rowp0_reg <= MW'(ye) * MW'(h_reg);
            rowp1_reg <= MW'(ye | PW'(1)) * MW'(h_reg);
        end
    end

    // Quotient step: divide by OUT_SIZE and clamp to the last sample
    function automatic logic [NW-1:0] div_out(input logic [MW-1:0] prod,
                                               input logic [NW-1:0] lim);
        logic [QPW-1:0] full;
        logic [NW-1:0]  q;
        full = QPW'(prod) * QPW'(RECIP);
        q    = full[K +: NW];
        return (q > lim) ? lim : q;
    endfunction

    logic [NW-1:0] ja_reg, jb_reg, ia_reg, ib_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.quot)
        begin
            ja_reg <= div_out(colp0_reg, w_reg - NW'(1));
            jb_reg <= div_out(colp1_reg, w_reg - NW'(1));
            ia_reg <= div_out(rowp0_reg, h_reg - NW'(1));
            ib_reg <= div_out(rowp1_reg, h_reg - NW'(1));
        end
    end

    // Address step: luma address and four chroma pair bases
    logic [NW-1:0]     jy, iy, cx_max, cy_max, cxa, cxb, cya, cyb;
    logic [2*NW:0]     luma_sum, rowa_base, rowb_base;
    logic [LAW-1:0]    luma_addr_reg;
    logic [CAW-1:0]    cbase_reg [4];

    always_comb
    begin
        jy        = px_reg[0] ? jb_reg : ja_reg;
        iy        = py_reg[0] ? ib_reg : ia_reg;
        cx_max    = (w_reg >> 1) - NW'(1);
        cy_max    = (h_reg >> 1) - NW'(1);
        cxa       = ((ja_reg >> 1) > cx_max) ? cx_max : (ja_reg >> 1);
        cxb       = ((jb_reg >> 1) > cx_max) ? cx_max : (jb_reg >> 1);
        cya       = ((ia_reg >> 1) > cy_max) ? cy_max : (ia_reg >> 1);
        cyb       = ((ib_reg >> 1) > cy_max) ? cy_max : (ib_reg >> 1);
        luma_sum  = (2*NW+1)'(iy) * (2*NW+1)'(w_reg) + (2*NW+1)'(jy);
        rowa_base = (2*NW+1)'(cya) * (2*NW+1)'(w_reg);
        rowb_base = (2*NW+1)'(cyb) * (2*NW+1)'(w_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            luma_addr_reg <= LAW'(luma_sum);
            cbase_reg[0]  <= CAW'(rowa_base + (2*NW+1)'({cxa, 1'b0}));
            cbase_reg[1]  <= CAW'(rowa_base + (2*NW+1)'({cxb, 1'b0}));
            cbase_reg[2]  <= CAW'(rowb_base + (2*NW+1)'({cxa, 1'b0}));
            cbase_reg[3]  <= CAW'(rowb_base + (2*NW+1)'({cxb, 1'b0}));
        end
    end

    // Chroma pair read: even and odd byte banks, one address each
    logic [CAW-1:0] rbase;
    logic [CAW:0]   rbase_ext;
    logic [BAW-1:0] even_ridx, odd_ridx;

    always_comb
    begin
        rbase     = cbase_reg[cmd.pair];
        rbase_ext = {1'b0, rbase};
        even_ridx = BAW'((rbase_ext + (CAW+1)'(1)) >> 1);
        odd_ridx  = BAW'(rbase_ext >> 1);
    end

    // Frame stores
    logic [7:0] luma_mem [LUMA_DEPTH];
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] luma_q_reg, even_q_reg, odd_q_reg;
    logic       swap_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_luma)
            luma_mem[lw_idx] <= in_item.data;
        if (cmd.rd && (cmd.pair == 2'd0))
            luma_q_reg <= luma_mem[luma_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_chroma && !cw_idx[0])
            even_mem[cw_bidx] <= in_item.data;
        if (cmd.rd)
            even_q_reg <= even_mem[even_ridx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_chroma && cw_idx[0])
            odd_mem[cw_bidx] <= in_item.data;
        if (cmd.rd)
            odd_q_reg <= odd_mem[odd_ridx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            swap_reg <= rbase[0];
    end

    // Chroma sums per byte position in the pair
    logic [7:0] ch0, ch1;
    logic [9:0] sum0_reg, sum1_reg;

    assign ch0 = swap_reg ? odd_q_reg : even_q_reg;
    assign ch1 = swap_reg ? even_q_reg : odd_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            sum0_reg <= 10'(ch0);
            sum1_reg <= 10'(ch1);
        end
        else if (cmd.acc)
        begin
            sum0_reg <= sum0_reg + 10'(ch0);
            sum1_reg <= sum1_reg + 10'(ch1);
        end
    end

    // Conversion products
    logic [7:0]              uu, vv;
    logic signed [8:0]       cb, cr;
    logic signed [PRODW-1:0] p_bu_reg, p_gu_reg, p_gv_reg, p_rv_reg, base_reg;

    always_comb
    begin
        vv = chroma_order_reg ? sum0_reg[9:2] : sum1_reg[9:2];
        uu = chroma_order_reg ? sum1_reg[9:2] : sum0_reg[9:2];
        cr = $signed({1'b0, vv}) - 9'sd128;
        cb = $signed({1'b0, uu}) - 9'sd128;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            p_bu_reg <= PRODW'(nvrr_pkg::K_BU) * PRODW'(cb);
            p_gu_reg <= PRODW'(nvrr_pkg::K_GU) * PRODW'(cb);
            p_gv_reg <= PRODW'(nvrr_pkg::K_GV) * PRODW'(cr);
            p_rv_reg <= PRODW'(nvrr_pkg::K_RV) * PRODW'(cr);
            base_reg <= $signed(PRODW'({luma_q_reg, {nvrr_pkg::Q_FRAC{1'b0}}}));
        end
    end

    // Floor, clamp to 0..255, subtract 128
    function automatic logic signed [7:0] to_pixel(input logic signed [PRODW-1:0] s);
        logic [PRODW-nvrr_pkg::Q_FRAC-1:0] v;
        logic [7:0]                        b;
        v = s[PRODW-1:nvrr_pkg::Q_FRAC];
        if (s < 0)
            b = 8'd0;
        else if (v > (PRODW-nvrr_pkg::Q_FRAC)'(255))
            b = 8'hFF;
        else
            b = v[7:0];
        return $signed({~b[7], b[6:0]});
    endfunction

    nvrr_pkg::out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.blue  <= to_pixel(base_reg + p_bu_reg);
            out_reg.green <= to_pixel(base_reg + p_gu_reg + p_gv_reg);
            out_reg.red   <= to_pixel(base_reg + p_rv_reg);
        end
    end

    assign out_item = out_reg;

endmodule

>>> design/nv21_resize_rotate_to_bgr_core.sv
// Compute: once the transaction is accepted the controller steps through the scale, divide
// and address steps, the four chroma pair reads from the even and odd byte banks, accumulate
// and convert, then loads the result; in_stall stays high until then. Loads stay in idle.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (rst_n, async low) clears the controller, output valid and config registers;
// frame stores are not cleared and must be written before they are read.
module nv21_resize_rotate_to_bgr_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int OUT_SIZE   = 384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  nvrr_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output nvrr_pkg::out_item_t              out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nvrr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nvrr_pkg::CFG_DIM_W-1:0]   cfg_data
);

    nvrr_pkg::nvrr_cmd_t cmd;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    nvrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_item.op),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    nvrr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .OUT_SIZE   (OUT_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

>>> tb/nv21_resize_rotate_to_bgr_core_tb.sv
// Self-checking testbench for the NV21/NV12 resize-rotate-to-BGR core.
// Loads frame bytes, requests output pixels and checks every BGR transaction against
// an in-bench conversion model or a fixed value. Depends on nvrr_pkg and the core.
module nv21_resize_rotate_to_bgr_core_tb;
    import nvrr_pkg::*;

    localparam int unsigned GRID_LAST      = 383;
    localparam int unsigned GRID_SIZE      = 384;
    localparam int unsigned DIM_MAX        = 1024;
    localparam int unsigned LUMA_DEPTH     = 1024 * 1024;
    localparam int unsigned CHROMA_DEPTH   = LUMA_DEPTH / 2;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          NUM_PHASES     = 10;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd15;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    // Frame setup and length of one random phase
    typedef struct packed {
        logic [CFG_DIM_W-1:0] width;
        logic [CFG_DIM_W-1:0] height;
        logic                 nv21;
        logic [1:0]           rot;
        logic [7:0]           items;
    } frame_setup_t;

    // DUT ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DIM_W-1:0]   cfg_data  = '0;

    // Shadow copy of the configuration registers
    logic [CFG_DIM_W-1:0] width_reg  = FRAME_WIDTH_RST;
    logic [CFG_DIM_W-1:0] height_reg = FRAME_HEIGHT_RST;
    logic                 nv21_reg   = CHROMA_ORDER_RST;
    logic [1:0]           rot_reg    = ROTATION_RST;

    // Shadow frame stores with written flags
    logic [7:0] luma_mem   [LUMA_DEPTH];
    bit         luma_set   [LUMA_DEPTH];
    logic [7:0] chroma_mem [CHROMA_DEPTH];
    bit         chroma_set [CHROMA_DEPTH];

    out_item_t    expected_bgr [$];
    out_item_t    head_bgr;
    dir_row_t     dir_rows [$];
    frame_setup_t phase_setup [NUM_PHASES];
    idle_mode_t   idle_mode   = IDLE_NONE;
    int           errors      = 0;
    int           idle_cycles = 0;
    int unsigned  items_sent  = 0;

    // Store addresses touched by the last located pixel
    int unsigned tap_luma;
    int unsigned tap_chroma [8];

    nv21_resize_rotate_to_bgr_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel model
    // ------------------------------------------------------------------

    function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > DIM_MAX)
            return DIM_MAX;
        return 32'(v);
    endfunction

    // Nearest source index for grid position p over n samples
    function automatic int unsigned scale_index(input int unsigned p, input int unsigned n);
        int unsigned q;
        q = (p * n) / GRID_SIZE;
        return (q > n - 1) ? n - 1 : q;
    endfunction

    // Undo rotation and find the luma byte and the eight chroma bytes read
    function automatic void locate_taps(input logic [COORD_W-1:0] ox,
                                        input logic [COORD_W-1:0] oy);
        int unsigned x, y, px, py, w, h, xe, ye, cmax, rmax;
        int unsigned col [2];
        int unsigned row [2];
        x = (ox > GRID_LAST) ? GRID_LAST : 32'(ox);
        y = (oy > GRID_LAST) ? GRID_LAST : 32'(oy);
        case (rot_reg)
            ROT_90:  begin px = GRID_LAST - y; py = x;             end
            ROT_180: begin px = GRID_LAST - x; py = GRID_LAST - y; end
            ROT_270: begin px = y;             py = GRID_LAST - x; end
            default: begin px = x;             py = y;             end
        endcase
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        tap_luma = (scale_index(py, h) * w + scale_index(px, w)) % LUMA_DEPTH;
        xe   = px & ~32'd1;
        ye   = py & ~32'd1;
        cmax = w / 2 - 1;
        rmax = h / 2 - 1;
        col[0] = scale_index(xe, w) >> 1;
        col[1] = scale_index(xe + 1, w) >> 1;
        row[0] = scale_index(ye, h) >> 1;
        row[1] = scale_index(ye + 1, h) >> 1;
        for (int i = 0; i < 2; i++)
        begin
            if (col[i] > cmax)
                col[i] = cmax;
            if (row[i] > rmax)
                row[i] = rmax;
        end
        // taps 0..3 are the even byte of each pair, 4..7 the odd byte
        for (int k = 0; k < 8; k++)
            tap_chroma[k] = (row[(k >> 1) & 1] * w + col[k & 1] * 2 + (k >> 2)) % CHROMA_DEPTH;
    endfunction

    // Floor, clamp to 0..255, remove the 128 offset
    function automatic logic signed [7:0] to_byte(input int s);
        int v;
        v = (s < 0) ? 0 : s / (1 << Q_FRAC);
        if (v > 255)
            v = 255;
        return 8'(v + 128);
    endfunction

    function automatic out_item_t bgr_of_pixel(input logic [COORD_W-1:0] ox,
                                               input logic [COORD_W-1:0] oy);
        int unsigned even_sum, odd_sum;
        int          yv, cr, cb, base;
        out_item_t   px;
        locate_taps(ox, oy);
        even_sum = 0;
        odd_sum  = 0;
        for (int k = 0; k < 4; k++)
        begin
            even_sum += 32'(chroma_mem[tap_chroma[k]]);
            odd_sum  += 32'(chroma_mem[tap_chroma[k + 4]]);
        end
        even_sum >>= 2;
        odd_sum  >>= 2;
        cr   = int'(nv21_reg ? even_sum : odd_sum) - 128;
        cb   = int'(nv21_reg ? odd_sum : even_sum) - 128;
        yv   = int'(luma_mem[tap_luma]);
        base = yv << Q_FRAC;
        px.blue  = to_byte(base + int'(K_BU) * cb);
        px.green = to_byte(base + int'(K_GU) * cb + int'(K_GV) * cr);
        px.red   = to_byte(base + int'(K_RV) * cr);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(7) == 0)
            return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
        return 8'($urandom());
    endfunction

    function automatic bit roll_idle(input bit sender_side);
        int unsigned pct;
        case (idle_mode)
            IDLE_SEND: pct = sender_side ? 70 : 0;
            IDLE_RECV: pct = sender_side ? 0 : 70;
            IDLE_BOTH: pct = 31;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic dir_row_t dir_row(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                         input logic [7:0] data, input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y, input logic typed,
                                         input out_item_t want);
        dir_row_t d;
        d.item.op    = op;
        d.item.addr  = addr;
        d.item.data  = data;
        d.item.out_x = x;
        d.item.out_y = y;
        d.typed      = typed;
        d.want       = want;
        return d;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Drive one input transaction and update the shadow state once accepted
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        while (roll_idle(1'b1))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        case (it.op)
            OP_LOAD_LUMA:
            begin
                luma_mem[it.addr] = it.data;
                luma_set[it.addr] = 1'b1;
            end
            OP_LOAD_CHROMA:
            begin
                chroma_mem[it.addr % CHROMA_DEPTH] = it.data;
                chroma_set[it.addr % CHROMA_DEPTH] = 1'b1;
            end
            OP_COMPUTE:
                expected_bgr.push_back(typed ? want : bgr_of_pixel(it.out_x, it.out_y));
            default: ;
        endcase
    endtask

    // Request a pixel, first loading any store byte it reads that is still unwritten
    task automatic send_pixel(input in_item_t it, input logic typed, input out_item_t want);
        int unsigned luma_a;
        int unsigned chroma_a [8];
        in_item_t    fill;
        locate_taps(it.out_x, it.out_y);
        luma_a   = tap_luma;
        chroma_a = tap_chroma;
        fill.out_x = COORD_W'($urandom());
        fill.out_y = COORD_W'($urandom());
        if (!luma_set[luma_a])
        begin
            fill.op   = OP_LOAD_LUMA;
            fill.addr = ADDR_W'(luma_a);
            fill.data = rand_byte();
            send_item(fill, 1'b0, '0);
        end
        foreach (chroma_a[k])
        begin
            if (!chroma_set[chroma_a[k]])
            begin
                fill.op   = OP_LOAD_CHROMA;
                fill.addr = ADDR_W'(chroma_a[k]);
                fill.data = rand_byte();
                send_item(fill, 1'b0, '0);
            end
        end
        send_item(it, typed, want);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:   width_reg  = val;
            CFG_FRAME_HEIGHT:  height_reg = val;
            CFG_CHROMA_ORDER:  nv21_reg   = val[0];
            CFG_ROTATION_CODE: rot_reg    = val[1:0];
            default: ;
        endcase
    endtask

    // Stop sending, wait for every pending pixel, then let the pipe run empty
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bgr.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bgr.size() == 0)
                report("result transaction with no pixel pending");
            else
            begin
                head_bgr = expected_bgr.pop_front();
                if (out_item.blue !== head_bgr.blue)
                    report($sformatf("blue %0d, want %0d", out_item.blue, head_bgr.blue));
                if (out_item.green !== head_bgr.green)
                    report($sformatf("green %0d, want %0d", out_item.green, head_bgr.green));
                if (out_item.red !== head_bgr.red)
                    report($sformatf("red %0d, want %0d", out_item.red, head_bgr.red));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= roll_idle(1'b0);
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        in_item_t     it;
        frame_setup_t fs;
        int unsigned  w_eff, h_eff, r, start;
        bit           paused;

        // Directed table, reset frame setup (640x480, NV21, no rotation).
        // Pixel (0,0) reads only luma 0 and chroma bytes 0 and 1.
        dir_rows.push_back(dir_row(OP_LOAD_LUMA,   20'd0, 8'd255, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'd0, 8'd128, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'd1, 8'd128, 9'd0, 9'd0, 1'b0, '0));
        // neutral chroma: white, black and mid gray
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd0, 1'b1,
                                   {8'sd127, 8'sd127, 8'sd127}));
        dir_rows.push_back(dir_row(OP_LOAD_LUMA, 20'd0, 8'd0, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd0, 1'b1,
                                   {-8'sd128, -8'sd128, -8'sd128}));
        dir_rows.push_back(dir_row(OP_LOAD_LUMA, 20'd128 - 20'd128, 8'd128, 9'd0, 9'd0, 1'b0, '0));
        // unused op must not touch the stores nor produce a result
        dir_rows.push_back(dir_row(OP_UNUSED, 20'd0, 8'd255, 9'd511, 9'd511, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd0, 1'b1, '0));
        // saturated chroma extremes
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'd0, 8'd255, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'd1, 8'd0, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd0, 1'b0, '0));
        // chroma address past the store wraps onto byte 1
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'h80001, 8'd255, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_LOAD_LUMA, 20'hFFFFF, 8'd255, 9'd0, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_LOAD_CHROMA, 20'hFFFFF, 8'd0, 9'd0, 9'd0, 1'b0, '0));
        // grid corners and positions past the grid edge
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd511, 9'd511, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd383, 9'd0, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd0, 9'd383, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'd0, 8'd0, 9'd383, 9'd383, 1'b0, '0));
        dir_rows.push_back(dir_row(OP_COMPUTE, 20'hFFFFF, 8'hFF, 9'd384, 9'd200, 1'b0, '0));

        // Random phases: sizes from minimum to maximum, odd and out of range
        phase_setup[0] = {11'd2,    11'd2,    1'b0, ROT_NONE, 8'd120};
        phase_setup[1] = {11'd8,    11'd6,    1'b1, ROT_90,   8'd120};
        phase_setup[2] = {11'd13,   11'd7,    1'b0, ROT_180,  8'd120};
        phase_setup[3] = {11'd0,    11'd1,    1'b1, ROT_270,  8'd120};
        phase_setup[4] = {11'd1024, 11'd1024, 1'b0, ROT_90,   8'd40};
        phase_setup[5] = {11'd2047, 11'd1025, 1'b1, ROT_NONE, 8'd40};
        phase_setup[6] = {11'd32,   11'd24,   1'b1, ROT_270,  8'd120};
        phase_setup[7] = {11'd5,    11'd33,   1'b0, ROT_180,  8'd120};
        phase_setup[8] = {11'd640,  11'd480,  1'b1, ROT_NONE, 8'd120};
        phase_setup[9] = {11'd17,   11'd3,    1'b1, ROT_90,   8'd120};

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write to an unused index must be ignored
        write_reg(CFG_SPARE, '1);
        cfg_valid <= 1'b0;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].item.op == OP_COMPUTE)
                send_pixel(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            else
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            fs = phase_setup[p];
            settle(SETTLE_CYCLES);
            // unused upper data bits are randomized on the narrow registers
            write_reg(CFG_FRAME_WIDTH, fs.width);
            write_reg(CFG_FRAME_HEIGHT, fs.height);
            write_reg(CFG_CHROMA_ORDER, {10'($urandom()), fs.nv21});
            write_reg(CFG_ROTATION_CODE, {9'($urandom()), fs.rot});
            cfg_valid <= 1'b0;

            idle_mode = idle_mode_t'(p % 4);
            w_eff  = eff_dim(fs.width);
            h_eff  = eff_dim(fs.height);
            start  = items_sent;
            paused = 1'b0;
            // store fills count toward the phase length
            while (items_sent - start < fs.items)
            begin
                // sender holds off once per phase until every pixel is back
                if (!paused && items_sent - start >= fs.items / 2)
                begin
                    settle(0);
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                it.op    = OP_LOAD_LUMA;
                it.addr  = ADDR_W'($urandom());
                it.data  = rand_byte();
                it.out_x = COORD_W'($urandom());
                it.out_y = COORD_W'($urandom());
                if (r < 35)
                    it.addr = ADDR_W'($urandom_range(w_eff * h_eff - 1));
                else if (r < 55)
                begin
                    it.op   = OP_LOAD_CHROMA;
                    it.addr = ADDR_W'($urandom_range(w_eff * h_eff / 2 - 1)
                            + (($urandom_range(7) == 0) ? CHROMA_DEPTH : 0));
                end
                else if (r < 90)
                begin
                    it.op = OP_COMPUTE;
                    if ($urandom_range(7) != 0)
                    begin
                        it.out_x = COORD_W'($urandom_range(GRID_LAST));
                        it.out_y = COORD_W'($urandom_range(GRID_LAST));
                    end
                end
                else if (r < 95)
                    it.op = ($urandom_range(1) == 0) ? OP_LOAD_LUMA : OP_LOAD_CHROMA;
                else
                    it.op = OP_UNUSED;

                if (it.op == OP_COMPUTE)
                    send_pixel(it, 1'b0, '0);
                else
                    send_item(it, 1'b0, '0);
            end
        end

        idle_mode = IDLE_NONE;
        settle(SETTLE_CYCLES);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
